[src/record_lock_set_table_defines.svh]
// Assertion macros for the record lock set table.
// Used by the RTL files that carry concurrent checks; expects clk and arst_n in scope.
`ifndef RECORD_LOCK_SET_TABLE_DEFINES_SVH
`define RECORD_LOCK_SET_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
`define RLST_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define RLST_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`else
`define RLST_ASSERT(lbl, prop, msg)
`define RLST_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

[src/rlst_pkg.sv]
// Shared types and codes for the record lock set table.
// No dependencies.
`timescale 1ns / 1ps
package rlst_pkg;

	localparam int KIND_W   = 3;
	localparam int REC_W    = 32;
	localparam int STATUS_W = 3;

	localparam logic [KIND_W-1:0] KIND_ADD   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_DEL   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_QUERY = 3'd2;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd3;
	localparam logic [KIND_W-1:0] KIND_FIRST = 3'd4;
	localparam logic [KIND_W-1:0] KIND_NEXT  = 3'd5;

	localparam logic [STATUS_W-1:0] ST_DONE     = 3'd0;
	localparam logic [STATUS_W-1:0] ST_PRESENT  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
	localparam logic [STATUS_W-1:0] ST_ZERO     = 3'd4;
	localparam logic [STATUS_W-1:0] ST_END      = 3'd5;

	// control broadcast to every cell of the ring
	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctl_t;

endpackage

[src/rlst_if.sv]
// Valid/ready channel interfaces for requests and responses.
// Depends on rlst_pkg for field widths.
`timescale 1ns / 1ps
interface rlst_req_if;
	logic                       valid;
	logic                       ready;
	logic [rlst_pkg::KIND_W-1:0] kind;
	logic [rlst_pkg::REC_W-1:0]  record;

	modport source (output valid, output kind, output record, input ready);
	modport sink   (input valid, input kind, input record, output ready);
endinterface

interface rlst_rsp_if;
	logic                         valid;
	logic                         ready;
	logic                         ok;
	logic [rlst_pkg::STATUS_W-1:0] status;
	logic [rlst_pkg::REC_W-1:0]    record_out;

	modport source (output valid, output ok, output status, output record_out, input ready);
	modport sink   (input valid, input ok, input status, input record_out, output ready);
endinterface

[src/record_lock_set_table.sv]
// Top level of the record lock set table: sequencer plus a ring of slot cells.
// Depends on rlst_pkg, rlst_if, rlst_cell and record_lock_set_table_defines.svh.
//
//  channel | dir | signals                          | transfer when
//  req     | in  | valid ready kind record          | valid && ready
//  rsp     | out | valid ready ok status record_out | valid && ready
//
// Add, delete, query, first and next: the request is taken in S_IDLE, the ring
// rotates once through every slot in S_SCAN and S_HOLD loads the result; an add
// that inserts rotates a second time in S_WRITE. Clear, unused kinds and zero
// records of add, delete or query skip the rotation. Reset empties all slots at once.
// A new request is taken as soon as the previous result sits in the output
// register; a stalled rsp holds the sequencer only once the next result is ready.
`timescale 1ns / 1ps
`include "record_lock_set_table_defines.svh"
module record_lock_set_table #(
	parameter int CAPACITY = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	rlst_req_if.sink   req,
	rlst_rsp_if.source rsp
);

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int RW = rlst_pkg::REC_W;

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_WRITE, S_HOLD} state_t;

	state_t                          state_q;
	logic [IW-1:0]                   cnt_q;
	logic [CW-1:0]                   cursor_q;
	logic [rlst_pkg::KIND_W-1:0]     kind_q;
	logic [RW-1:0]                   rec_q;
	logic                            hit_q, free_seen_q, walk_found_q;
	logic [IW-1:0]                   free_idx_q, walk_idx_q;
	logic [RW-1:0]                   walk_rec_q;
	logic                            res_ok_q;
	logic [rlst_pkg::STATUS_W-1:0]   res_status_q;
	logic [RW-1:0]                   res_rec_q;
	logic                            rsp_valid_q, rsp_ok_q;
	logic [rlst_pkg::STATUS_W-1:0]   rsp_status_q;
	logic [RW-1:0]                   rsp_rec_q;

	rlst_pkg::cell_ctl_t ctl;
	logic [RW-1:0]       slot_val [CAPACITY];
	logic [RW-1:0]       head, head_wr;
	logic                cnt_last;
	logic                rsp_load;
	logic                hit_d, free_seen_d, walk_found_d;
	logic [IW-1:0]       free_idx_d, walk_idx_d;
	logic [RW-1:0]       walk_rec_d;

	// ring: cell 0 is the head, its (possibly rewritten) value wraps to the tail
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [RW-1:0] nxt;
		if (i == CAPACITY - 1) begin : g_tail
			assign nxt = head_wr;
		end else begin : g_mid
			assign nxt = slot_val[i+1];
		end
		rlst_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.nxt    (nxt),
			.value  (slot_val[i])
		);
	end

	assign head     = slot_val[0];
	assign cnt_last = (cnt_q == IW'(CAPACITY - 1));
	assign rsp_load = (state_q == S_HOLD) && (!rsp_valid_q || rsp.ready);

	always_comb begin
		head_wr = head;
		if (state_q == S_SCAN && kind_q == rlst_pkg::KIND_DEL && head == rec_q) begin
			head_wr = '0;
		end else if (state_q == S_WRITE && cnt_q == free_idx_q) begin
			head_wr = rec_q;
		end
	end

	assign ctl.shift = (state_q == S_SCAN) || (state_q == S_WRITE);
	assign ctl.clear = (state_q == S_IDLE) && req.valid && (req.kind == rlst_pkg::KIND_CLEAR);

	// scan flags including the slot now at the head
	always_comb begin
		hit_d        = hit_q || (head == rec_q);
		free_seen_d  = free_seen_q;
		free_idx_d   = free_idx_q;
		walk_found_d = walk_found_q;
		walk_idx_d   = walk_idx_q;
		walk_rec_d   = walk_rec_q;
		if (!free_seen_q && head == '0) begin
			free_seen_d = 1'b1;
			free_idx_d  = cnt_q;
		end
		if (!walk_found_q && head != '0 && CW'(cnt_q) >= cursor_q) begin
			walk_found_d = 1'b1;
			walk_idx_d   = cnt_q;
			walk_rec_d   = head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			cursor_q     <= CW'(CAPACITY);
			kind_q       <= '0;
			rec_q        <= '0;
			hit_q        <= 1'b0;
			free_seen_q  <= 1'b0;
			walk_found_q <= 1'b0;
			free_idx_q   <= '0;
			walk_idx_q   <= '0;
			walk_rec_q   <= '0;
			res_ok_q     <= 1'b0;
			res_status_q <= rlst_pkg::ST_DONE;
			res_rec_q    <= '0;
			rsp_valid_q  <= 1'b0;
			rsp_ok_q     <= 1'b0;
			rsp_status_q <= rlst_pkg::ST_DONE;
			rsp_rec_q    <= '0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						kind_q       <= req.kind;
						rec_q        <= req.record;
						cnt_q        <= '0;
						hit_q        <= 1'b0;
						free_seen_q  <= 1'b0;
						walk_found_q <= 1'b0;
						res_ok_q     <= 1'b0;
						res_status_q <= rlst_pkg::ST_DONE;
						res_rec_q    <= '0;
						unique case (req.kind)
							rlst_pkg::KIND_ADD, rlst_pkg::KIND_DEL: begin
								cursor_q <= CW'(CAPACITY);
								if (req.record == '0) begin
									res_status_q <= rlst_pkg::ST_ZERO;
									state_q      <= S_HOLD;
								end else begin
									state_q <= S_SCAN;
								end
							end
							rlst_pkg::KIND_QUERY: begin
								if (req.record == '0) begin
									res_status_q <= rlst_pkg::ST_ZERO;
									state_q      <= S_HOLD;
								end else begin
									state_q <= S_SCAN;
								end
							end
							rlst_pkg::KIND_CLEAR: begin
								cursor_q <= CW'(CAPACITY);
								res_ok_q <= 1'b1;
								state_q  <= S_HOLD;
							end
							rlst_pkg::KIND_FIRST: begin
								cursor_q <= '0;
								state_q  <= S_SCAN;
							end
							rlst_pkg::KIND_NEXT: begin
								state_q <= S_SCAN;
							end
							default: begin
								state_q <= S_HOLD;
							end
						endcase
					end
				end
				S_SCAN: begin
					cnt_q        <= cnt_last ? '0 : cnt_q + IW'(1);
					hit_q        <= hit_d;
					free_seen_q  <= free_seen_d;
					free_idx_q   <= free_idx_d;
					walk_found_q <= walk_found_d;
					walk_idx_q   <= walk_idx_d;
					walk_rec_q   <= walk_rec_d;
					if (cnt_last) begin
						state_q <= S_HOLD;
						unique case (kind_q)
							rlst_pkg::KIND_ADD: begin
								if (hit_d) begin
									res_status_q <= rlst_pkg::ST_PRESENT;
								end else if (!free_seen_d) begin
									res_status_q <= rlst_pkg::ST_FULL;
								end else begin
									res_ok_q <= 1'b1;
									state_q  <= S_WRITE;
								end
							end
							rlst_pkg::KIND_DEL, rlst_pkg::KIND_QUERY: begin
								res_ok_q     <= hit_d;
								res_status_q <= hit_d ? rlst_pkg::ST_DONE : rlst_pkg::ST_NOTFOUND;
							end
							rlst_pkg::KIND_FIRST, rlst_pkg::KIND_NEXT: begin
								if (walk_found_d) begin
									res_ok_q  <= 1'b1;
									res_rec_q <= walk_rec_d;
									cursor_q  <= CW'(walk_idx_d) + CW'(1);
								end else begin
									res_status_q <= rlst_pkg::ST_END;
									cursor_q     <= CW'(CAPACITY);
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_WRITE: begin
					cnt_q <= cnt_last ? '0 : cnt_q + IW'(1);
					if (cnt_last) begin
						state_q <= S_HOLD;
					end
				end
				S_HOLD: begin
					if (rsp_load) begin
						rsp_ok_q     <= res_ok_q;
						rsp_status_q <= res_status_q;
						rsp_rec_q    <= res_rec_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req.ready      = (state_q == S_IDLE);
	assign rsp.valid      = rsp_valid_q;
	assign rsp.ok         = rsp_ok_q;
	assign rsp.status     = rsp_status_q;
	assign rsp.record_out = rsp_rec_q;

	`RLST_ASSERT(a_cursor_range, cursor_q <= CW'(CAPACITY), "walk cursor beyond end position")
	`RLST_ASSERT_IMPL(a_aligned_on_accept, req.valid && req.ready, cnt_q == '0, "ring not aligned at request transfer")
	`RLST_ASSERT_IMPL(a_write_only_add, state_q == S_WRITE, free_seen_q && kind_q == rlst_pkg::KIND_ADD, "insert pass without free slot")
	`RLST_ASSERT_IMPL(a_ok_means_done, rsp.valid && rsp.ok, rsp.status == rlst_pkg::ST_DONE, "ok with error status")
	`RLST_ASSERT_IMPL(a_rec_means_ok, rsp.valid && rsp.record_out != '0, rsp.ok, "record returned without ok")

endmodule

[src/rlst_cell.sv]
// One slot of the rotating ring: holds a record and passes it to its neighbor on shift.
// Depends on rlst_pkg.
`timescale 1ns / 1ps
module rlst_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  rlst_pkg::cell_ctl_t        ctl,
	input  logic [rlst_pkg::REC_W-1:0] nxt,
	output logic [rlst_pkg::REC_W-1:0] value
);

	logic [rlst_pkg::REC_W-1:0] slot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (ctl.clear) begin
			slot_q <= '0;
		end else if (ctl.shift) begin
			slot_q <= nxt;
		end
	end

	assign value = slot_q;

endmodule
